FILE: hw/rtl/scp_pkg.sv
`timescale 1ns / 1ps
package scp_pkg;

  localparam int MAX_ROWS_DEF   = 8;
  localparam int SCORE_BITS_DEF = 32;

  localparam int SYM_BITS     = 3;
  localparam int NUM_SLOTS    = 8;
  localparam int COL_BITS     = NUM_SLOTS * SYM_BITS;
  localparam int ROW_CNT_BITS = 4;
  localparam int TBL_IDX_BITS = 6;
  localparam int TBL_DEPTH    = 1 << TBL_IDX_BITS;
  localparam int TBL_VAL_BITS = 16;
  localparam int PEN_BITS     = 16;
  localparam int OUT_BITS     = 32;
  localparam int LANE_W       = TBL_VAL_BITS + 2;
  localparam int GRP_SIZE     = 8;
  localparam int GRP_W        = LANE_W + 3;
  localparam int FIFO_DEPTH   = 8;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [SYM_BITS-1:0] DASH_CODE = 3'd6;
  localparam logic [SYM_BITS-1:0] FREE_CODE = 3'd7;

  localparam logic OP_TABLE  = 1'b0;
  localparam logic OP_COLUMN = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_ONE_ROW_MODE = 2'd1,
    REG_FOCUS_ROW    = 2'd2,
    REG_GAP_PENALTY  = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] GT_RESIDUE = 2'd0;
  localparam logic [1:0] GT_DASH    = 2'd1;
  localparam logic [1:0] GT_FREE    = 2'd2;

  localparam int NUM_OPEN = 10;
  localparam logic [7:0] OPEN_PATTERNS [NUM_OPEN] = '{
    8'h01, 8'h04, 8'h24, 8'h14, 8'h81, 8'h91, 8'h41, 8'h64, 8'h51, 8'h54
  };

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic [ROW_CNT_BITS-1:0] row_count;
    logic                    one_row;
    logic [SYM_BITS-1:0]     focus;
    logic [PEN_BITS-1:0]     penalty;
  } cfg_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] total;
    logic                       sat;
  } res_t;

  function automatic logic [1:0] gap_type(input logic [SYM_BITS-1:0] s);
    logic [1:0] g;
    if (s == FREE_CODE) g = GT_FREE;
    else if (s == DASH_CODE) g = GT_DASH;
    else g = GT_RESIDUE;
    return g;
  endfunction

  function automatic logic is_open(input logic [7:0] code);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_OPEN; k++) begin
      if (OPEN_PATTERNS[k] == code) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic int num_pairs(input int rows);
    return rows * (rows - 1) / 2;
  endfunction

  function automatic int num_lanes(input int rows);
    int np;
    np = num_pairs(rows);
    return (np > rows) ? np : rows;
  endfunction

  function automatic int pair_first(input int k, input int rows);
    int n;
    int res;
    n = 0;
    res = 0;
    for (int r = 0; r < rows; r++) begin
      for (int i = r + 1; i < rows; i++) begin
        if (n == k) res = r;
        n++;
      end
    end
    return res;
  endfunction

  function automatic int pair_second(input int k, input int rows);
    int n;
    int res;
    n = 0;
    res = 0;
    for (int r = 0; r < rows; r++) begin
      for (int i = r + 1; i < rows; i++) begin
        if (n == k) res = i;
        n++;
      end
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/sum_of_pairs_column_scorer.sv
`timescale 1ns / 1ps
// A last column's score passes the table-read, group-sum, column-sum and accumulator registers and result queue.
// Throughput: one word (table write or column) per cycle while in_ready is high; every pair has its own
// lane with a private copy of the substitution table, merged by a two-level adder tree.
// in_ready drops only when the 8-entry result queue plus results in flight would overflow.
// Reset (synchronous, rst_n low) clears config to defaults, score, clamp flag and
// previous column; the substitution table is not cleared.
module sum_of_pairs_column_scorer import scp_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [COL_BITS-1:0]            in_column_symbols,
  input  logic                           in_first_column,
  input  logic                           in_last_column,
  input  logic [TBL_IDX_BITS-1:0]        in_table_index,
  input  logic signed [TBL_VAL_BITS-1:0] in_table_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [OUT_BITS-1:0]     out_total_score,
  output logic                           out_saturated,
  input  logic                           cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]       cfg_wdata
);

  localparam int NLANE = num_lanes(MAX_ROWS);
  localparam int CW    = $clog2(FIFO_DEPTH) + 1;

  cfg_t                cfg_r;
  logic [COL_BITS-1:0] prev_col_r;
  ctl_t                ctl1_r;
  logic                accept;
  logic                col_acc;
  logic                tbl_wr;
  logic [NLANE-1:0][LANE_W-1:0] lane_val;
  logic                res_vld;
  res_t                res;
  res_t                fifo_out;
  logic [1:0]          pend;
  logic [CW-1:0]       fifo_cnt;
  logic [CW:0]         credit_used;

  assign accept  = in_valid & in_ready;
  assign col_acc = accept & (in_opcode == OP_COLUMN);
  assign tbl_wr  = accept & (in_opcode == OP_TABLE);

  assign credit_used = (CW + 1)'(fifo_cnt) + (CW + 1)'(pend) +
                       (CW + 1)'(ctl1_r.vld & ctl1_r.last);
  assign in_ready    = credit_used < (CW + 1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count <= ROW_CNT_BITS'(MAX_ROWS_DEF);
      cfg_r.one_row   <= 1'b0;
      cfg_r.focus     <= '0;
      cfg_r.penalty   <= PEN_BITS'(400);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_COUNT:    cfg_r.row_count <= cfg_wdata[ROW_CNT_BITS-1:0];
        REG_ONE_ROW_MODE: cfg_r.one_row   <= cfg_wdata[0];
        REG_FOCUS_ROW:    cfg_r.focus     <= cfg_wdata[SYM_BITS-1:0];
        REG_GAP_PENALTY:  cfg_r.penalty   <= cfg_wdata[PEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_col_r <= '0;
      ctl1_r     <= '0;
    end else begin
      ctl1_r.vld   <= col_acc;
      ctl1_r.first <= in_first_column;
      ctl1_r.last  <= in_last_column;
      if (col_acc) prev_col_r <= in_column_symbols;
    end
  end

  generate
    for (genvar k = 0; k < NLANE; k++) begin : g_lane
      scp_lane #(
        .MAX_ROWS (MAX_ROWS),
        .LANE     (k),
        .PA       (pair_first(k, MAX_ROWS)),
        .PB       (pair_second(k, MAX_ROWS))
      ) u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tbl_wr),
        .wr_idx   (in_table_index),
        .wr_val   (in_table_value),
        .rd_en    (col_acc),
        .gap_en   (~in_first_column),
        .cur_col  (in_column_symbols),
        .prev_col (prev_col_r),
        .cfg      (cfg_r),
        .lane_val (lane_val[k])
      );
    end
  endgenerate

  scp_merge #(
    .MAX_ROWS   (MAX_ROWS),
    .SCORE_BITS (SCORE_BITS)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (ctl1_r),
    .lane_val (lane_val),
    .res_vld  (res_vld),
    .res      (res),
    .pend     (pend)
  );

  scp_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .out_vld   (out_valid),
    .out_rdy   (out_ready),
    .out_data  (fifo_out),
    .count     (fifo_cnt)
  );

  assign out_total_score = fifo_out.total;
  assign out_saturated   = fifo_out.sat;

endmodule

FILE: hw/rtl/scp_lane.sv
`timescale 1ns / 1ps
module scp_lane import scp_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int LANE     = 0,
  parameter int PA       = 0,
  parameter int PB       = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [TBL_IDX_BITS-1:0]        wr_idx,
  input  logic signed [TBL_VAL_BITS-1:0] wr_val,
  input  logic                           rd_en,
  input  logic                           gap_en,
  input  logic [COL_BITS-1:0]            cur_col,
  input  logic [COL_BITS-1:0]            prev_col,
  input  cfg_t                           cfg,
  output logic signed [LANE_W-1:0]       lane_val
);

  localparam int NPAIR = num_pairs(MAX_ROWS);

  logic signed [TBL_VAL_BITS-1:0] mem [TBL_DEPTH];
  logic signed [TBL_VAL_BITS-1:0] sub_r;
  logic                           hit_r;
  logic                           act_r;

  logic [NUM_SLOTS-1:0][SYM_BITS-1:0] cur_sym;
  logic [NUM_SLOTS-1:0][SYM_BITS-1:0] prev_sym;
  logic [SYM_BITS-1:0] a_idx;
  logic [SYM_BITS-1:0] b_idx;
  logic [SYM_BITS-1:0] ca;
  logic [SYM_BITS-1:0] cb;
  logic                act;
  logic                hit;

  assign cur_sym  = cur_col;
  assign prev_sym = prev_col;

  always_comb begin
    if (cfg.one_row) begin
      a_idx = cfg.focus;
      b_idx = SYM_BITS'(LANE);
      act   = (LANE < MAX_ROWS) && (cfg.focus != SYM_BITS'(LANE)) &&
              (ROW_CNT_BITS'(LANE) < cfg.row_count);
    end else begin
      a_idx = SYM_BITS'(PA);
      b_idx = SYM_BITS'(PB);
      act   = (LANE < NPAIR) && (ROW_CNT_BITS'(PB) < cfg.row_count);
    end
    ca  = cur_sym[a_idx];
    cb  = cur_sym[b_idx];
    hit = gap_en && is_open({gap_type(prev_sym[a_idx]), gap_type(prev_sym[b_idx]),
                             gap_type(ca), gap_type(cb)});
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_val;
    end
    if (rd_en) begin
      sub_r <= mem[{ca, cb}];
      hit_r <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (rd_en) begin
      act_r <= act;
    end
  end

  always_comb begin
    if (!act_r) begin
      lane_val = '0;
    end else if (hit_r) begin
      lane_val = LANE_W'(sub_r) - $signed({2'b00, cfg.penalty});
    end else begin
      lane_val = LANE_W'(sub_r);
    end
  end

endmodule

FILE: hw/rtl/scp_merge.sv
`timescale 1ns / 1ps
module scp_merge import scp_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ctl_t                                ctl_in,
  input  logic [num_lanes(MAX_ROWS)-1:0][LANE_W-1:0] lane_val,
  output logic                                res_vld,
  output res_t                                res,
  output logic [1:0]                          pend
);

  localparam int NLANE = num_lanes(MAX_ROWS);
  localparam int NGRP  = (NLANE + GRP_SIZE - 1) / GRP_SIZE;
  localparam int COL_W = GRP_W + $clog2(NGRP) + 1;
  localparam int SB    = SCORE_BITS;

  localparam logic signed [SB-1:0] ACC_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] ACC_MIN = {1'b1, {(SB-1){1'b0}}};

  logic signed [GRP_W-1:0] grp_nxt [NGRP];
  logic signed [GRP_W-1:0] grp_r   [NGRP];
  logic signed [COL_W-1:0] col_nxt;
  logic signed [COL_W-1:0] col_r;
  ctl_t                    ctl2_r;
  ctl_t                    ctl3_r;
  ctl_t                    ctl4_r;
  logic signed [SB-1:0]    acc_r;
  logic signed [SB-1:0]    acc_nxt;
  logic                    flag_r;
  logic                    flag_nxt;
  logic signed [SB-1:0]    base;
  logic signed [SB:0]      sum;
  logic                    ovf;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < NLANE) begin
          grp_nxt[g] = grp_nxt[g] + GRP_W'($signed(lane_val[g * GRP_SIZE + j]));
        end
      end
    end
  end

  always_comb begin
    col_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      col_nxt = col_nxt + COL_W'(grp_r[g]);
    end
  end

  always_comb begin
    base     = ctl3_r.first ? '0 : acc_r;
    sum      = (SB + 1)'(base) + (SB + 1)'(col_r);
    ovf      = sum[SB] != sum[SB-1];
    acc_nxt  = ovf ? (sum[SB] ? ACC_MIN : ACC_MAX) : sum[SB-1:0];
    flag_nxt = (ctl3_r.first ? 1'b0 : flag_r) | ovf;
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
    col_r <= col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      acc_r  <= '0;
      flag_r <= 1'b0;
    end else begin
      ctl2_r <= ctl_in;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      if (ctl3_r.vld) begin
        acc_r  <= acc_nxt;
        flag_r <= flag_nxt;
      end
    end
  end

  generate
    if (SB > OUT_BITS) begin : g_clamp
      logic fits;
      assign fits = (&acc_r[SB-1:OUT_BITS-1]) | ~(|acc_r[SB-1:OUT_BITS-1]);
      assign res.total = fits ? acc_r[OUT_BITS-1:0] :
                         (acc_r[SB-1] ? {1'b1, {(OUT_BITS-1){1'b0}}}
                                      : {1'b0, {(OUT_BITS-1){1'b1}}});
      assign res.sat   = flag_r | ~fits;
    end else begin : g_ext
      assign res.total = OUT_BITS'(acc_r);
      assign res.sat   = flag_r;
    end
  endgenerate

  assign res_vld = ctl4_r.vld & ctl4_r.last;
  assign pend    = 2'(ctl2_r.vld & ctl2_r.last) + 2'(ctl3_r.vld & ctl3_r.last) +
                   2'(ctl4_r.vld & ctl4_r.last);

endmodule

FILE: hw/rtl/scp_out_fifo.sv
`timescale 1ns / 1ps
module scp_out_fifo import scp_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  res_t                       push_data,
  output logic                       out_vld,
  input  logic                       out_rdy,
  output res_t                       out_data,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int PW = $clog2(DEPTH);

  res_t          mem [DEPTH];
  logic [PW-1:0] head_r;
  logic [PW-1:0] tail_r;
  logic [PW:0]   cnt_r;
  logic          pop;

  assign out_vld  = cnt_r != '0;
  assign out_data = mem[head_r];
  assign pop      = out_vld & out_rdy;
  assign count    = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) tail_r <= tail_r + 1'b1;
      if (pop) head_r <= head_r + 1'b1;
      cnt_r <= cnt_r + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

endmodule
